[hw/rtl/pfe_pkg.sv]
// Shared types, constants and a helper function of the periodic force effect generator.
package pfe_pkg;

	// Waveform codes
	typedef enum logic [1:0] {
		WAVE_SQUARE    = 2'd0,
		WAVE_TRIANGLE  = 2'd1,
		WAVE_SAW_DOWN  = 2'd2,
		WAVE_SAW_UP    = 2'd3
	} wave_t;

	localparam int unsigned FORCE_W = 21;
	localparam logic [31:0] DIV_K = 32'd255;
	// Largest product magnitude that still divides into the force range: 255 * 2^20
	localparam logic [27:0] PROD_LIM = 28'd267386880;
	localparam logic [20:0] FORCE_POS_MAX = 21'h0FFFFF;

	// Divide by 255: reciprocal series estimate, then correct the remainder
	function automatic logic [31:0] div255(input logic [31:0] x);
		logic [33:0] s;
		logic [31:0] e;
		logic [31:0] r;
		s = {2'b00, x} + {10'd0, x[31:8]} + {18'd0, x[31:16]} + {26'd0, x[31:24]};
		e = {6'd0, s[33:8]};
		r = x - ((e << 8) - e);
		if (r >= DIV_K) begin
			e = e + 32'd1;
			r = r - DIV_K;
		end
		if (r >= DIV_K) begin
			e = e + 32'd1;
		end
		return e;
	endfunction

endpackage

[hw/rtl/pfe_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband tag.
module pfe_div #(
	parameter int unsigned NW = 32,
	parameter int unsigned DW = 16,
	parameter int unsigned TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem,
	output logic [TW-1:0] tag_out
);

	logic [NW-1:0] nq_s  [NW];
	logic [DW-1:0] rem_s [NW];
	logic [DW-1:0] den_s [NW];
	logic [TW-1:0] tag_s [NW];
	logic [NW-1:0] vld_s;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [NW-1:0] nq_c;
		logic [DW-1:0] rem_c;
		logic [DW-1:0] den_c;
		logic [TW-1:0] tag_c;
		logic          v_c;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          take;

		// Select the stage input
		if (k == 0) begin : g_first
			assign nq_c  = num;
			assign rem_c = {DW{1'b0}};
			assign den_c = den;
			assign tag_c = tag_in;
			assign v_c   = in_valid;
		end else begin : g_next
			assign nq_c  = nq_s[k-1];
			assign rem_c = rem_s[k-1];
			assign den_c = den_s[k-1];
			assign tag_c = tag_s[k-1];
			assign v_c   = vld_s[k-1];
		end

		// Shift in the next numerator bit and try to subtract
		assign trial = {rem_c, nq_c[NW-1]};
		assign diff  = trial - {1'b0, den_c};
		assign take  = (trial >= {1'b0, den_c});

		// Advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_c;
			end
		end

		// Advance the partial remainder and quotient
		always_ff @(posedge clk) begin
			nq_s[k]  <= {nq_c[NW-2:0], take};
			rem_s[k] <= take ? diff[DW-1:0] : trial[DW-1:0];
			den_s[k] <= den_c;
			tag_s[k] <= tag_c;
		end
	end

	assign out_valid = vld_s[NW-1];
	assign quo       = nq_s[NW-1];
	assign rem       = rem_s[NW-1];
	assign tag_out   = tag_s[NW-1];

endmodule

[hw/rtl/periodic_force_effect_generator.sv]
// Top level of the periodic force effect generator.
// One effect item is taken on every cycle in which start is high; busy is always low, since
// the pipeline never stalls. Each item returns one signed force on force_res, marked by done
// for one cycle. The latency is set by the divider pipelines (position modulo period:
// 17 stages, wave divide by period: 34 stages, attack and fade ramp divides in parallel:
// 32 stages) plus ten register stages around them; results leave in order.
module periodic_force_effect_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         waveform,
	input  logic [13:0]        magnitude,
	input  logic signed [13:0] offset,
	input  logic [7:0]         phase,
	input  logic [15:0]        period,
	input  logic [15:0]        elapsed,
	input  logic [15:0]        duration,
	input  logic [13:0]        attack_level,
	input  logic [15:0]        attack_time,
	input  logic [13:0]        fade_level,
	input  logic [15:0]        fade_time,
	input  logic [7:0]         gain,
	output logic               done,
	output logic signed [pfe_pkg::FORCE_W-1:0] force_res
);

	typedef struct packed {
		logic [13:0] gm;
		logic [13:0] ga;
		logic [13:0] gf;
		logic [15:0] el;
		logic [15:0] dur;
		logic [15:0] atim;
		logic [15:0] ftim;
	} env_t;

	typedef struct packed {
		pfe_pkg::wave_t     form;
		logic [13:0]        mag;
		logic signed [16:0] lo;
		logic signed [16:0] hi;
		logic [15:0]        p;
		env_t               env;
	} pos_tag_t;

	typedef struct packed {
		pfe_pkg::wave_t     form;
		logic signed [16:0] lo;
		logic signed [16:0] hi;
		logic               gt;
		logic               pz;
		logic               neg;
		env_t               env;
	} wave_tag_t;

	typedef struct packed {
		logic signed [17:0] wave;
		logic [13:0]        gm;
		logic [13:0]        ga;
		logic [13:0]        gf;
		logic               acond;
		logic               fcond;
		logic               asgn;
	} lvl_tag_t;

	// ---------------- stage 1: register inputs, form products ----------------
	logic               v_s1;
	pfe_pkg::wave_t     form_s1;
	logic [13:0]        mag_s1;
	logic signed [13:0] off_s1;
	logic [23:0]        php_s1;
	logic [21:0]        gmp_s1;
	logic [21:0]        gap_s1;
	logic [21:0]        gfp_s1;
	logic [15:0]        p_s1;
	logic [15:0]        el_s1;
	logic [15:0]        dur_s1;
	logic [15:0]        atim_s1;
	logic [15:0]        ftim_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		form_s1 <= pfe_pkg::wave_t'(waveform);
		mag_s1  <= magnitude;
		off_s1  <= offset;
		php_s1  <= phase * period;
		gmp_s1  <= magnitude * gain;
		gap_s1  <= attack_level * gain;
		gfp_s1  <= fade_level * gain;
		p_s1    <= period;
		el_s1   <= elapsed;
		dur_s1  <= duration;
		atim_s1 <= attack_time;
		ftim_s1 <= fade_time;
	end

	// ---------------- stage 2: scale by 1/255, wave bounds ----------------
	logic [31:0]        qph_c;
	logic [31:0]        gm_c;
	logic [31:0]        ga_c;
	logic [31:0]        gf_c;
	logic signed [16:0] off2_c;
	logic               v_s2;
	logic [16:0]        sum_s2;
	logic [15:0]        p_s2;
	pos_tag_t           ptag_s2;

	assign qph_c  = pfe_pkg::div255({8'd0, php_s1});
	assign gm_c   = pfe_pkg::div255({10'd0, gmp_s1});
	assign ga_c   = pfe_pkg::div255({10'd0, gap_s1});
	assign gf_c   = pfe_pkg::div255({10'd0, gfp_s1});
	assign off2_c = {{2{off_s1[13]}}, off_s1, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2           <= {1'b0, el_s1} + {1'b0, qph_c[15:0]};
		p_s2             <= p_s1;
		ptag_s2.form     <= form_s1;
		ptag_s2.mag      <= mag_s1;
		ptag_s2.lo       <= off2_c - $signed({3'b000, mag_s1});
		ptag_s2.hi       <= off2_c + $signed({3'b000, mag_s1});
		ptag_s2.p        <= p_s1;
		ptag_s2.env.gm   <= gm_c[13:0];
		ptag_s2.env.ga   <= ga_c[13:0];
		ptag_s2.env.gf   <= gf_c[13:0];
		ptag_s2.env.el   <= el_s1;
		ptag_s2.env.dur  <= dur_s1;
		ptag_s2.env.atim <= atim_s1;
		ptag_s2.env.ftim <= ftim_s1;
	end

	// ---------------- position: sum modulo period ----------------
	logic        v_m;
	logic [15:0] pos_m;
	pos_tag_t    ptag_m;

	pfe_div #(
		.NW (17),
		.DW (16),
		.TW ($bits(pos_tag_t))
	) u_pos_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.num       (sum_s2),
		.den       (p_s2),
		.tag_in    (ptag_s2),
		.out_valid (v_m),
		.quo       (),
		.rem       (pos_m),
		.tag_out   (ptag_m)
	);

	// ---------------- stage 3: wave numerator products ----------------
	logic [15:0]        half_c;
	logic               gt_c;
	logic [15:0]        rpos_c;
	logic [16:0]        y_c;
	logic [31:0]        prod_a_c;
	logic signed [33:0] prod_l_c;
	logic               v_s3;
	logic [31:0]        prod_a_s3;
	logic signed [33:0] prod_l_s3;
	logic [15:0]        p_s3;
	wave_tag_t          wtag_s3;

	assign half_c = ptag_m.p >> 1;
	assign gt_c   = (pos_m > half_c);
	assign rpos_c = ptag_m.p - pos_m;

	// Pick the ramp operand for the waveform
	always_comb begin
		case (ptag_m.form)
			pfe_pkg::WAVE_TRIANGLE: y_c = gt_c ? {rpos_c, 1'b0} : {pos_m, 1'b0};
			pfe_pkg::WAVE_SAW_DOWN: y_c = {1'b0, rpos_c};
			pfe_pkg::WAVE_SAW_UP:   y_c = {1'b0, pos_m};
			default:                y_c = 17'd0;
		endcase
	end

	assign prod_a_c = {ptag_m.mag, 1'b0} * y_c;
	assign prod_l_c = ptag_m.lo * $signed({1'b0, ptag_m.p});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_m;
		end
	end

	always_ff @(posedge clk) begin
		prod_a_s3    <= prod_a_c;
		prod_l_s3    <= prod_l_c;
		p_s3         <= ptag_m.p;
		wtag_s3.form <= ptag_m.form;
		wtag_s3.lo   <= ptag_m.lo;
		wtag_s3.hi   <= ptag_m.hi;
		wtag_s3.gt   <= gt_c;
		wtag_s3.pz   <= (ptag_m.p == 16'd0);
		wtag_s3.neg  <= 1'b0;
		wtag_s3.env  <= ptag_m.env;
	end

	// ---------------- stage 4: sign and magnitude of the numerator ----------------
	logic signed [34:0] num_c;
	logic [34:0]        nabs_c;
	wave_tag_t          wtag_c;
	logic               v_s4;
	logic [33:0]        nmag_s4;
	logic [15:0]        p_s4;
	wave_tag_t          wtag_s4;

	assign num_c  = $signed({3'b000, prod_a_s3}) + $signed({prod_l_s3[33], prod_l_s3});
	assign nabs_c = num_c[34] ? 35'(-num_c) : 35'(num_c);

	// Carry the tag forward with the numerator sign
	always_comb begin
		wtag_c     = wtag_s3;
		wtag_c.neg = num_c[34];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		nmag_s4 <= nabs_c[33:0];
		p_s4    <= p_s3;
		wtag_s4 <= wtag_c;
	end

	// ---------------- wave: numerator over period ----------------
	logic        v_w;
	logic [33:0] qw_w;
	wave_tag_t   wtag_w;

	pfe_div #(
		.NW (34),
		.DW (16),
		.TW ($bits(wave_tag_t))
	) u_wave_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.num       (nmag_s4),
		.den       (p_s4),
		.tag_in    (wtag_s4),
		.out_valid (v_w),
		.quo       (qw_w),
		.rem       (),
		.tag_out   (wtag_w)
	);

	// ---------------- stage 5: wave select, envelope ramp products ----------------
	logic signed [34:0] wq_c;
	logic signed [17:0] wave_c;
	logic signed [14:0] da_c;
	logic signed [14:0] df_c;
	logic signed [16:0] del_c;
	logic               v_s5;
	logic signed [17:0] wave_s5;
	logic signed [31:0] pa_s5;
	logic signed [31:0] pf_s5;
	env_t               env_s5;

	assign wq_c = wtag_w.neg ? -$signed({1'b0, qw_w}) : $signed({1'b0, qw_w});

	// Resolve zero period and square wave, else take the quotient
	always_comb begin
		if (wtag_w.pz) begin
			if (wtag_w.form == pfe_pkg::WAVE_SQUARE || wtag_w.form == pfe_pkg::WAVE_SAW_DOWN) begin
				wave_c = {wtag_w.hi[16], wtag_w.hi};
			end else begin
				wave_c = {wtag_w.lo[16], wtag_w.lo};
			end
		end else if (wtag_w.form == pfe_pkg::WAVE_SQUARE) begin
			wave_c = wtag_w.gt ? {wtag_w.lo[16], wtag_w.lo} : {wtag_w.hi[16], wtag_w.hi};
		end else begin
			wave_c = wq_c[17:0];
		end
	end

	assign da_c  = $signed({1'b0, wtag_w.env.gm}) - $signed({1'b0, wtag_w.env.ga});
	assign df_c  = $signed({1'b0, wtag_w.env.gm}) - $signed({1'b0, wtag_w.env.gf});
	assign del_c = $signed({1'b0, wtag_w.env.dur}) - $signed({1'b0, wtag_w.env.el});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_w;
		end
	end

	always_ff @(posedge clk) begin
		wave_s5 <= wave_c;
		pa_s5   <= da_c * $signed({1'b0, wtag_w.env.el});
		pf_s5   <= df_c * del_c;
		env_s5  <= wtag_w.env;
	end

	// ---------------- stage 6: ramp magnitudes and envelope conditions ----------------
	logic        v_s6;
	logic [31:0] amag_s6;
	logic [31:0] fmag_s6;
	logic [15:0] atim_s6;
	logic [15:0] ftim_s6;
	logic        fsgn_s6;
	lvl_tag_t    ltag_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		amag_s6       <= pa_s5[31] ? 32'(-pa_s5) : 32'(pa_s5);
		fmag_s6       <= pf_s5[31] ? 32'(-pf_s5) : 32'(pf_s5);
		atim_s6       <= env_s5.atim;
		ftim_s6       <= env_s5.ftim;
		fsgn_s6       <= pf_s5[31];
		ltag_s6.wave  <= wave_s5;
		ltag_s6.gm    <= env_s5.gm;
		ltag_s6.ga    <= env_s5.ga;
		ltag_s6.gf    <= env_s5.gf;
		ltag_s6.acond <= (env_s5.el < env_s5.atim);
		ltag_s6.fcond <= (env_s5.ftim != 16'd0) &&
			(({1'b0, env_s5.el} + {1'b0, env_s5.ftim}) > {1'b0, env_s5.dur});
		ltag_s6.asgn  <= pa_s5[31];
	end

	// ---------------- envelope: attack and fade ramps ----------------
	logic        va_e;
	logic        vf_e;
	logic [31:0] qa_e;
	logic [31:0] qf_e;
	lvl_tag_t    ltag_e;
	logic        fsgn_e;

	pfe_div #(
		.NW (32),
		.DW (16),
		.TW ($bits(lvl_tag_t))
	) u_attack_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.num       (amag_s6),
		.den       (atim_s6),
		.tag_in    (ltag_s6),
		.out_valid (va_e),
		.quo       (qa_e),
		.rem       (),
		.tag_out   (ltag_e)
	);

	pfe_div #(
		.NW (32),
		.DW (16),
		.TW (1)
	) u_fade_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.num       (fmag_s6),
		.den       (ftim_s6),
		.tag_in    (fsgn_s6),
		.out_valid (vf_e),
		.quo       (qf_e),
		.rem       (),
		.tag_out   (fsgn_e)
	);

	// ---------------- stage 7: envelope level ----------------
	logic signed [33:0] sa_c;
	logic signed [33:0] sf_c;
	logic signed [33:0] la_c;
	logic signed [33:0] lf_c;
	logic signed [33:0] lvl_c;
	logic               v_s7;
	logic signed [33:0] lvl_s7;
	logic signed [17:0] wave_s7;

	assign sa_c = ltag_e.asgn ? -$signed({2'b00, qa_e}) : $signed({2'b00, qa_e});
	assign sf_c = fsgn_e ? -$signed({2'b00, qf_e}) : $signed({2'b00, qf_e});
	assign la_c = sa_c + $signed({20'd0, ltag_e.ga});
	assign lf_c = sf_c + $signed({20'd0, ltag_e.gf});

	// Fade overrides attack, attack overrides the sustain level
	always_comb begin
		lvl_c = $signed({20'd0, ltag_e.gm});
		if (ltag_e.acond) begin
			lvl_c = la_c;
		end
		if (ltag_e.fcond) begin
			lvl_c = lf_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= va_e & vf_e;
		end
	end

	always_ff @(posedge clk) begin
		lvl_s7  <= lvl_c;
		wave_s7 <= ltag_e.wave;
	end

	// ---------------- stage 8: level times wave ----------------
	logic               v_s8;
	logic signed [51:0] prod_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		prod_s8 <= lvl_s7 * wave_s7;
	end

	// ---------------- stage 9: magnitude, clamp to force range ----------------
	logic [51:0] pabs_c;
	logic        v_s9;
	logic        neg_s9;
	logic [27:0] pcl_s9;

	assign pabs_c = prod_s8[51] ? 52'(-prod_s8) : 52'(prod_s8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		neg_s9 <= prod_s8[51];
		pcl_s9 <= (pabs_c >= {24'd0, pfe_pkg::PROD_LIM}) ? pfe_pkg::PROD_LIM : pabs_c[27:0];
	end

	// ---------------- stage 10: divide by 255, saturate, drive result ----------------
	logic [31:0] fq_c;
	logic [20:0] fmag_c;

	assign fq_c   = pfe_pkg::div255({4'd0, pcl_s9});
	assign fmag_c = fq_c[20:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (neg_s9) begin
			force_res <= $signed(-fmag_c);
		end else if (fmag_c > pfe_pkg::FORCE_POS_MAX) begin
			force_res <= $signed(pfe_pkg::FORCE_POS_MAX);
		end else begin
			force_res <= $signed(fmag_c);
		end
	end

endmodule
